// File: hdl/aie_pkg.sv
// Shared types and codes for the accumulator instruction execute unit.
// Used by aie_dmem, aie_muldiv and accumulator_instruction_execute_unit.
// No dependencies.
package aie_pkg;

	localparam int MEM_DEPTH_DEF = 256;
	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [4:0] {
		OP_HALT  = 5'd0,
		OP_LOAD  = 5'd1,
		OP_LOADI = 5'd2,
		OP_STORE = 5'd3,
		OP_ADD   = 5'd4,
		OP_ADDI  = 5'd5,
		OP_SUB   = 5'd6,
		OP_SUBI  = 5'd7,
		OP_MUL   = 5'd8,
		OP_MULI  = 5'd9,
		OP_DIV   = 5'd10,
		OP_DIVI  = 5'd11,
		OP_MOD   = 5'd12,
		OP_MODI  = 5'd13,
		OP_CMP   = 5'd14,
		OP_CMPI  = 5'd15,
		OP_JMP   = 5'd16,
		OP_JE    = 5'd17,
		OP_JNE   = 5'd18,
		OP_JL    = 5'd19,
		OP_JLE   = 5'd20,
		OP_JG    = 5'd21,
		OP_JGE   = 5'd22,
		OP_IN    = 5'd23,
		OP_OUT   = 5'd24
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_HALT  = 3'd1,
		ST_MEM   = 3'd2,
		ST_DIV0  = 3'd3,
		ST_BADOP = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MD_MUL = 2'd0,
		MD_DIV = 2'd1,
		MD_MOD = 2'd2
	} md_op_t;

	typedef struct packed {
		logic   start;
		md_op_t op;
	} md_cmd_t;

	typedef struct packed {
		logic we;
		logic re;
	} mem_cmd_t;

endpackage

// File: hdl/accumulator_instruction_execute_unit.sv
// Execute stage of a small accumulator machine: sequencer, architectural state,
// result register. Depends on aie_pkg, aie_dmem and aie_muldiv.
//
// After reset the data memory is swept to zero, one word a cycle, so no request
// is taken until the sweep is done. A preload passes through S_EXEC1 and S_RESP,
// most instructions through S_EXEC1, S_EXEC2 and S_RESP, and MUL, DIV and MOD
// also wait in S_WAIT, since the shared multiply/divide unit retires one bit a
// cycle. The data memory has a single port with a registered read. A finished
// result sits in the output register while the next request is accepted.
module accumulator_instruction_execute_unit #(
	parameter int MEM_DEPTH = aie_pkg::MEM_DEPTH_DEF,
	parameter int WORD_BITS = aie_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               req_type,
	input  logic [4:0]         opcode,
	input  logic [15:0]        operand,
	input  logic [7:0]         in_byte,
	input  logic signed [31:0] preload_word,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [2:0]         status,
	output logic signed [31:0] acc_value,
	output logic [15:0]        next_ip,
	output logic               out_valid,
	output logic [7:0]         out_byte,
	output logic               zero_flag_out,
	output logic               sign_flag_out
);

	localparam int         W         = WORD_BITS;
	localparam int         AW        = $clog2(MEM_DEPTH);
	localparam logic [16:0] DEPTH_LIM = 17'(MEM_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_EXEC1, S_EXEC2, S_WAIT, S_RESP} state_t;

	state_t               state_q;
	logic                 req_type_q;
	aie_pkg::opcode_t     opcode_q;
	logic [15:0]          operand_q;
	logic [7:0]           in_byte_q;
	logic signed [31:0]   pw_q;
	logic [W-1:0]         acc_q;
	logic                 zf_q;
	logic                 sf_q;
	logic [15:0]          ip_q;
	logic                 run_q;
	aie_pkg::status_t     st_q;
	logic                 outv_q;

	logic                 res_valid_q;
	logic [2:0]           status_q;
	logic signed [31:0]   acc_out_q;
	logic [15:0]          next_ip_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 zf_out_q;
	logic                 sf_out_q;

	aie_pkg::mem_cmd_t    mem_cmd;
	logic [W-1:0]         mem_wdata;
	logic [W-1:0]         mem_rdata;
	logic                 mem_busy;
	aie_pkg::md_cmd_t     md_cmd;
	logic [W-1:0]         md_result;
	logic                 md_done;

	logic                 is_mem;
	logic                 is_div;
	logic                 op_bad;
	logic                 addr_bad;
	logic [W-1:0]         x;
	logic                 div0;
	logic [W-1:0]         diff;
	logic                 jump;
	logic                 out_free;

	always_comb begin
		is_mem = opcode_q inside {aie_pkg::OP_LOAD, aie_pkg::OP_STORE, aie_pkg::OP_ADD,
			aie_pkg::OP_SUB, aie_pkg::OP_MUL, aie_pkg::OP_DIV, aie_pkg::OP_MOD,
			aie_pkg::OP_CMP};
		is_div = opcode_q inside {[aie_pkg::OP_DIV:aie_pkg::OP_MODI]};
		op_bad   = (opcode_q > aie_pkg::OP_OUT);
		addr_bad = ({1'b0, operand_q} >= DEPTH_LIM);
		x        = is_mem ? mem_rdata : W'(operand_q);
		div0     = is_div && (x == '0);
		diff     = acc_q - x;
		out_free = !res_valid_q || res_ready;

		case (opcode_q)
			aie_pkg::OP_JMP: jump = 1'b1;
			aie_pkg::OP_JE:  jump = zf_q;
			aie_pkg::OP_JNE: jump = !zf_q;
			aie_pkg::OP_JL:  jump = sf_q;
			aie_pkg::OP_JLE: jump = sf_q || zf_q;
			aie_pkg::OP_JG:  jump = !zf_q && !sf_q;
			aie_pkg::OP_JGE: jump = zf_q || !sf_q;
			default:         jump = 1'b0;
		endcase

		mem_cmd   = '0;
		mem_wdata = acc_q;
		if (state_q == S_EXEC1) begin
			if (req_type_q) begin
				mem_cmd.we = !addr_bad;
				mem_wdata  = W'(pw_q);
			end else begin
				mem_cmd.re = run_q && !op_bad && is_mem && !addr_bad;
			end
		end else if (state_q == S_EXEC2) begin
			mem_cmd.we = (opcode_q == aie_pkg::OP_STORE);
		end

		md_cmd.op = aie_pkg::MD_MUL;
		if (opcode_q == aie_pkg::OP_DIV || opcode_q == aie_pkg::OP_DIVI) begin
			md_cmd.op = aie_pkg::MD_DIV;
		end else if (opcode_q == aie_pkg::OP_MOD || opcode_q == aie_pkg::OP_MODI) begin
			md_cmd.op = aie_pkg::MD_MOD;
		end
		md_cmd.start = (state_q == S_EXEC2) && !div0 && (is_div ||
			opcode_q == aie_pkg::OP_MUL || opcode_q == aie_pkg::OP_MULI);
	end

	aie_dmem #(
		.DEPTH (MEM_DEPTH),
		.WIDTH (W)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.addr   (operand_q[AW-1:0]),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	aie_muldiv #(
		.W (W)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (md_cmd),
		.a      (acc_q),
		.b      (x),
		.result (md_result),
		.done   (md_done)
	);

	assign req_ready = (state_q == S_IDLE) && !mem_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_type_q  <= 1'b0;
			opcode_q    <= aie_pkg::OP_HALT;
			operand_q   <= '0;
			in_byte_q   <= '0;
			pw_q        <= '0;
			acc_q       <= '0;
			zf_q        <= 1'b0;
			sf_q        <= 1'b0;
			ip_q        <= '0;
			run_q       <= 1'b1;
			st_q        <= aie_pkg::ST_OK;
			outv_q      <= 1'b0;
			res_valid_q <= 1'b0;
			status_q    <= '0;
			acc_out_q   <= '0;
			next_ip_q   <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			zf_out_q    <= 1'b0;
			sf_out_q    <= 1'b0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						req_type_q <= req_type;
						opcode_q   <= aie_pkg::opcode_t'(opcode);
						operand_q  <= operand;
						in_byte_q  <= in_byte;
						pw_q       <= preload_word;
						st_q       <= aie_pkg::ST_OK;
						outv_q     <= 1'b0;
						state_q    <= S_EXEC1;
					end
				end
				S_EXEC1: begin
					state_q <= S_RESP;
					if (req_type_q) begin
						if (addr_bad) begin
							st_q <= aie_pkg::ST_MEM;
						end
					end else if (!run_q) begin
						st_q <= aie_pkg::ST_HALT;
					end else if (op_bad) begin
						st_q  <= aie_pkg::ST_BADOP;
						run_q <= 1'b0;
					end else if (is_mem && addr_bad) begin
						st_q  <= aie_pkg::ST_MEM;
						run_q <= 1'b0;
					end else begin
						state_q <= S_EXEC2;
					end
				end
				S_EXEC2: begin
					state_q <= S_RESP;
					if (div0) begin
						st_q  <= aie_pkg::ST_DIV0;
						run_q <= 1'b0;
					end else if (md_cmd.start) begin
						state_q <= S_WAIT;
					end else begin
						ip_q <= jump ? operand_q : ip_q + 16'd1;
						case (opcode_q)
							aie_pkg::OP_HALT: begin
								run_q <= 1'b0;
								st_q  <= aie_pkg::ST_HALT;
							end
							aie_pkg::OP_LOAD, aie_pkg::OP_LOADI: acc_q <= x;
							aie_pkg::OP_ADD, aie_pkg::OP_ADDI:   acc_q <= acc_q + x;
							aie_pkg::OP_SUB, aie_pkg::OP_SUBI:   acc_q <= diff;
							aie_pkg::OP_CMP, aie_pkg::OP_CMPI: begin
								zf_q <= (diff == '0);
								sf_q <= diff[W-1];
							end
							aie_pkg::OP_IN:  acc_q  <= W'(in_byte_q);
							aie_pkg::OP_OUT: outv_q <= 1'b1;
							default: begin
							end
						endcase
					end
				end
				S_WAIT: begin
					if (md_done) begin
						acc_q   <= md_result;
						ip_q    <= ip_q + 16'd1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						status_q    <= st_q;
						acc_out_q   <= 32'(acc_q);
						next_ip_q   <= ip_q;
						out_valid_q <= outv_q;
						out_byte_q  <= outv_q ? acc_q[7:0] : 8'd0;
						zf_out_q    <= zf_q;
						sf_out_q    <= sf_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign status        = status_q;
	assign acc_value     = acc_out_q;
	assign next_ip       = next_ip_q;
	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign zero_flag_out = zf_out_q;
	assign sign_flag_out = sf_out_q;

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !req_ready)
		else $error("request taken during memory clear");

	a_md_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_done |-> (state_q == S_WAIT))
		else $error("multiply/divide result outside wait state");

	a_stop_has_status: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> (st_q != aie_pkg::ST_OK))
		else $error("machine stopped with ok status");

	a_ip_update_point: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ip_q) |-> ($past(state_q) == S_EXEC2 || $past(state_q) == S_WAIT))
		else $error("instruction pointer changed outside execute");

endmodule

// File: hdl/aie_dmem.sv
// Data memory, single port, registered read, with a clearing sweep after reset.
// Depends on aie_pkg (mem_cmd_t).
module aie_dmem #(
	parameter int DEPTH = aie_pkg::MEM_DEPTH_DEF,
	parameter int WIDTH = aie_pkg::WORD_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aie_pkg::mem_cmd_t   cmd,
	input  logic [AW-1:0]       addr,
	input  logic [WIDTH-1:0]    wdata,
	output logic [WIDTH-1:0]    rdata,
	output logic                busy
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;
	logic [AW-1:0]    clr_q;
	logic             busy_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [WIDTH-1:0] wr_data;

	always_comb begin
		wr_en   = busy_q | cmd.we;
		wr_addr = busy_q ? clr_q : addr;
		wr_data = busy_q ? '0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// File: hdl/aie_muldiv.sv
// Iterative multiply, signed divide and signed modulo, one bit per cycle
// through a single shared adder. Depends on aie_pkg (md_cmd_t, md_op_t).
module aie_muldiv #(
	parameter int W = aie_pkg::WORD_BITS_DEF,
	localparam int CW = $clog2(W)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  aie_pkg::md_cmd_t  cmd,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      result,
	output logic              done
);

	typedef enum logic [1:0] {U_IDLE, U_RUN, U_FIX} ustate_t;

	ustate_t          state_q;
	aie_pkg::md_op_t  op_q;
	logic [W:0]       r_q;
	logic [W-1:0]     d_q;
	logic [W-1:0]     s_q;
	logic [CW-1:0]    cnt_q;
	logic             negq_q;
	logic             nega_q;

	logic             is_mul;
	logic [W:0]       add_a;
	logic [W:0]       add_b;
	logic             cin;
	logic [W:0]       sum;
	logic [W:0]       rem_sh;
	logic             qbit;
	logic [W-1:0]     a_mag;
	logic [W-1:0]     b_mag;

	always_comb begin
		is_mul = (op_q == aie_pkg::MD_MUL);
		rem_sh = {r_q[W-1:0], s_q[W-1]};
		add_a  = is_mul ? r_q : rem_sh;
		add_b  = is_mul ? (s_q[0] ? {1'b0, d_q} : '0) : ~{1'b0, d_q};
		cin    = ~is_mul;
		sum    = add_a + add_b + (W+1)'(cin);
		qbit   = ~sum[W];
		a_mag  = a[W-1] ? ('0 - a) : a;
		b_mag  = b[W-1] ? ('0 - b) : b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			op_q    <= aie_pkg::MD_MUL;
			r_q     <= '0;
			d_q     <= '0;
			s_q     <= '0;
			cnt_q   <= '0;
			negq_q  <= 1'b0;
			nega_q  <= 1'b0;
		end else begin
			case (state_q)
				U_IDLE: begin
					if (cmd.start) begin
						op_q    <= cmd.op;
						r_q     <= '0;
						cnt_q   <= CW'(W - 1);
						negq_q  <= a[W-1] ^ b[W-1];
						nega_q  <= a[W-1];
						state_q <= U_RUN;
						if (cmd.op == aie_pkg::MD_MUL) begin
							d_q <= a;
							s_q <= b;
						end else begin
							d_q <= b_mag;
							s_q <= a_mag;
						end
					end
				end
				U_RUN: begin
					if (is_mul) begin
						r_q <= {1'b0, sum[W-1:0]};
						d_q <= d_q << 1;
						s_q <= s_q >> 1;
					end else begin
						r_q <= qbit ? sum : rem_sh;
						s_q <= {s_q[W-2:0], qbit};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= U_FIX;
					end
				end
				U_FIX: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			aie_pkg::MD_DIV: result = negq_q ? ('0 - s_q) : s_q;
			aie_pkg::MD_MOD: result = nega_q ? ('0 - r_q[W-1:0]) : r_q[W-1:0];
			default:         result = r_q[W-1:0];
		endcase
	end

	assign done = (state_q == U_FIX);

endmodule
